// File: rtl/cobb_pkg.sv
// Shared widths, reset values and register indexes for the capsule bounding box core.
package cobb_pkg;

  localparam int PosW    = 32;
  localparam int QuatW   = 16;
  localparam int LenW    = 31;
  localparam int VolW    = 64;

  // Rotated axis in Q.28, its magnitude, and the scaled magnitude (Q.44).
  localparam int AxisW   = 34;
  localparam int MagW    = AxisW - 1;
  localparam int ScaleW  = MagW + LenW;
  localparam int FracCut = 28;

  // Half extent per axis (|top| plus radius) and corner before saturation.
  localparam int ReachW  = ScaleW - FracCut;
  localparam int CornerW = ReachW + 2;

  // Volume multiplier slicing.
  localparam int SplitW  = 18;
  localparam int ChunkW  = 24;
  localparam int NumChunk = (2 * ReachW) / ChunkW;
  localparam int PairW   = 2 * ReachW;
  localparam int PpW     = ChunkW + SplitW;
  localparam int PartW   = PpW + SplitW;
  localparam int ProdW   = 3 * ReachW;

  // Volume = 8 * h0*h1*h2 / 2^32, so take the triple product from this bit.
  localparam int VolLsb  = 29;
  localparam int VolTop  = VolLsb + VolW;

  localparam int NumStages = 9;

  localparam logic [LenW-1:0] HalfLengthReset = LenW'(65536);
  localparam logic [LenW-1:0] RadiusReset     = LenW'(32768);
  localparam logic signed [AxisW-1:0] AxisOne = AxisW'(64'sd268435456);
  localparam logic [ScaleW-1:0] RoundHalf     = ScaleW'(64'd134217728);

  typedef enum logic [0:0] {
    CfgHalfLength = 1'b0,
    CfgRadius     = 1'b1
  } cfg_idx_e;

endpackage

// File: rtl/capsule_oriented_bounding_box_core.sv
// Capsule bounding box: nine-stage pipeline from centre and quaternion to box and volume.
// Each accepted input word passes through stage registers 0 to 8 to its result word on the output.
// Throughput: one word per cycle; each stage holds only while the stage after it is full
// and stalled, so bubbles close up and input is taken while a result waits.
// Volume: a 36x36x36-bit product cut into 36x18 and 24x18 partial products over five stages.
// Reset clears all valid bits and loads half_length = 1.0 and radius = 0.5.
module capsule_oriented_bounding_box_core
  import cobb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  cfg_idx_e                 cfg_idx_i,
  input  logic [LenW-1:0]          cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic signed [PosW-1:0]   pos_x_i,
  input  logic signed [PosW-1:0]   pos_y_i,
  input  logic signed [PosW-1:0]   pos_z_i,
  input  logic signed [QuatW-1:0]  quat_w_i,
  input  logic signed [QuatW-1:0]  quat_x_i,
  input  logic signed [QuatW-1:0]  quat_y_i,
  input  logic signed [QuatW-1:0]  quat_z_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PosW-1:0]   low_x_o,
  output logic signed [PosW-1:0]   low_y_o,
  output logic signed [PosW-1:0]   low_z_o,
  output logic signed [PosW-1:0]   high_x_o,
  output logic signed [PosW-1:0]   high_y_o,
  output logic signed [PosW-1:0]   high_z_o,
  output logic [VolW-1:0]          volume_o,
  output logic                     clipped_o
);

  typedef struct packed {
    logic                   func;
    logic                   clip;
    logic [2:0][PosW-1:0]   lo;
    logic [2:0][PosW-1:0]   hi;
  } box_t;

  localparam int ProdQW = 2 * QuatW;

  function automatic logic [PosW:0] sat32(input logic signed [CornerW-1:0] v);
    logic ovf;
    ovf = !((&v[CornerW-1:PosW-1]) || !(|v[CornerW-1:PosW-1]));
    if (!ovf) begin
      sat32 = {1'b0, v[PosW-1:0]};
    end else if (v[CornerW-1]) begin
      sat32 = {1'b1, 1'b1, {(PosW-1){1'b0}}};
    end else begin
      sat32 = {1'b1, 1'b0, {(PosW-1){1'b1}}};
    end
  endfunction

  // Configuration
  logic [LenW-1:0] hl_q, rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q  <= HalfLengthReset;
      rad_q <= RadiusReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfLength: hl_q  <= cfg_data_i;
        CfgRadius:     rad_q <= cfg_data_i;
      endcase
    end
  end

  // Stage control: a stage loads when it is empty or the next one moves.
  logic [NumStages-1:0] v_q, rdy, ld;

  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ld = rdy & {v_q[NumStages-2:0], in_valid_i};
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 0: quaternion products
  logic                          func0_q;
  logic [2:0][PosW-1:0]          pos0_q;
  logic signed [ProdQW-1:0]      xz_q, wy_q, yz_q, wx_q, xx_q, yy_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      func0_q <= func_i;
      pos0_q  <= {pos_z_i, pos_y_i, pos_x_i};
      xz_q    <= quat_x_i * quat_z_i;
      wy_q    <= quat_w_i * quat_y_i;
      yz_q    <= quat_y_i * quat_z_i;
      wx_q    <= quat_w_i * quat_x_i;
      xx_q    <= quat_x_i * quat_x_i;
      yy_q    <= quat_y_i * quat_y_i;
    end
  end

  // Stage 1: rotated axis and its magnitude
  logic signed [AxisW-1:0]  ax_d [3];
  logic [2:0][MagW-1:0]     mag1_d, mag1_q;
  logic                     func1_q;
  logic [2:0][PosW-1:0]     pos1_q;

  always_comb begin
    ax_d[0] = (AxisW'(xz_q) + AxisW'(wy_q)) <<< 1;
    ax_d[1] = (AxisW'(yz_q) - AxisW'(wx_q)) <<< 1;
    ax_d[2] = AxisOne - ((AxisW'(xx_q) + AxisW'(yy_q)) <<< 1);
    for (int k = 0; k < 3; k++) begin
      mag1_d[k] = ax_d[k][AxisW-1] ? MagW'(-ax_d[k]) : ax_d[k][MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      func1_q <= func0_q;
      pos1_q  <= pos0_q;
      mag1_q  <= mag1_d;
    end
  end

  // Stage 2: scale by half length
  logic                      func2_q;
  logic [2:0][PosW-1:0]      pos2_q;
  logic [2:0][ScaleW-1:0]    scl2_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      func2_q <= func1_q;
      pos2_q  <= pos1_q;
      for (int k = 0; k < 3; k++) begin
        scl2_q[k] <= mag1_q[k] * hl_q;
      end
    end
  end

  // Stage 3: round to Q20.16 and add the radius pad in mode 0
  logic [2:0][ScaleW-1:0]    rnd_d;
  logic [2:0][ReachW-1:0]    reach3_d, reach3_q;
  logic                      func3_q;
  logic [2:0][PosW-1:0]      pos3_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd_d[k]    = scl2_q[k] + RoundHalf;
      reach3_d[k] = func2_q ? rnd_d[k][ScaleW-1:FracCut]
                            : rnd_d[k][ScaleW-1:FracCut] + ReachW'(rad_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      func3_q  <= func2_q;
      pos3_q   <= pos2_q;
      reach3_q <= reach3_d;
    end
  end

  // Stage 4: corners with saturation; first volume partial products
  box_t                          box4_d, box4_q;
  logic [ReachW+SplitW-1:0]      ppa4_q, ppb4_q;
  logic [ReachW-1:0]             h2_4_q;

  always_comb begin
    logic signed [CornerW-1:0] pe, he, lo_w, hi_w;
    logic [PosW:0]             s_lo, s_hi;
    box4_d.func = func3_q;
    box4_d.clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pe   = CornerW'($signed(pos3_q[k]));
      he   = $signed({2'b00, reach3_q[k]});
      lo_w = pe - he;
      hi_w = pe + he;
      s_lo = sat32(lo_w);
      s_hi = sat32(hi_w);
      box4_d.lo[k] = s_lo[PosW-1:0];
      box4_d.hi[k] = s_hi[PosW-1:0];
      box4_d.clip  = box4_d.clip | s_lo[PosW] | s_hi[PosW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      box4_q <= box4_d;
      ppa4_q <= reach3_q[0] * reach3_q[1][SplitW-1:0];
      ppb4_q <= reach3_q[0] * reach3_q[1][ReachW-1:SplitW];
      h2_4_q <= reach3_q[2];
    end
  end

  // Stage 5: combine into h0*h1
  box_t                box5_q;
  logic [PairW-1:0]    h01_5_q;
  logic [ReachW-1:0]   h2_5_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      box5_q  <= box4_q;
      h01_5_q <= PairW'(ppa4_q) + (PairW'(ppb4_q) << SplitW);
      h2_5_q  <= h2_4_q;
    end
  end

  // Stage 6: chunks of h0*h1 times halves of h2
  box_t                              box6_q;
  logic [NumChunk-1:0][1:0][PpW-1:0] pp6_q;

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      box6_q <= box5_q;
      for (int i = 0; i < NumChunk; i++) begin
        pp6_q[i][0] <= h01_5_q[ChunkW*i +: ChunkW] * h2_5_q[SplitW-1:0];
        pp6_q[i][1] <= h01_5_q[ChunkW*i +: ChunkW] * h2_5_q[ReachW-1:SplitW];
      end
    end
  end

  // Stage 7: fold each chunk's pair
  box_t                           box7_q;
  logic [NumChunk-1:0][PartW-1:0] part7_q;

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      box7_q <= box6_q;
      for (int i = 0; i < NumChunk; i++) begin
        part7_q[i] <= PartW'(pp6_q[i][0]) + (PartW'(pp6_q[i][1]) << SplitW);
      end
    end
  end

  // Stage 8: final sum, volume saturation, output register
  logic [ProdW-1:0]  prod_d;
  logic              vovf_d;
  logic [VolW-1:0]   vol_d, vol_q;
  logic              clip_d, clip_q;
  box_t              box8_q;

  always_comb begin
    prod_d = ProdW'(part7_q[0]);
    for (int i = 1; i < NumChunk; i++) begin
      prod_d = prod_d + (ProdW'(part7_q[i]) << (ChunkW * i));
    end
    vovf_d = |prod_d[ProdW-1:VolTop];
    if (box7_q.func) begin
      vol_d = '0;
    end else if (vovf_d) begin
      vol_d = '1;
    end else begin
      vol_d = prod_d[VolTop-1:VolLsb];
    end
    clip_d = box7_q.clip | (!box7_q.func && vovf_d);
  end

  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      box8_q <= box7_q;
      vol_q  <= vol_d;
      clip_q <= clip_d;
    end
  end

  assign out_valid_o = v_q[NumStages-1];
  assign low_x_o     = box8_q.lo[0];
  assign low_y_o     = box8_q.lo[1];
  assign low_z_o     = box8_q.lo[2];
  assign high_x_o    = box8_q.hi[0];
  assign high_y_o    = box8_q.hi[1];
  assign high_z_o    = box8_q.hi[2];
  assign volume_o    = vol_q;
  assign clipped_o   = clip_q;

  // Checks
  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (low_x_o <= high_x_o) && (low_y_o <= high_y_o) && (low_z_o <= high_z_o))
    else $error("box corners out of order");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(low_x_o) && $stable(low_y_o)
      && $stable(low_z_o) && $stable(high_x_o) && $stable(high_y_o) && $stable(high_z_o)
      && $stable(volume_o) && $stable(clipped_o))
    else $error("stalled result word changed");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled with a free pipeline slot");

  a_bare_no_volume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && box8_q.func |-> (volume_o == '0))
    else $error("segment-bounds word carries a volume");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the capsule bounding box core: random handshakes, predicted boxes.
module testbench;
  import cobb_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int RandPerPhase = 155;
  localparam int NumPhases = 9;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  typedef struct {
    bit                      func;
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic signed [PosW-1:0]  pos_z;
    logic signed [QuatW-1:0] quat_w;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
  } capsule_t;

  typedef struct {
    logic signed [PosW-1:0] low_x;
    logic signed [PosW-1:0] low_y;
    logic signed [PosW-1:0] low_z;
    logic signed [PosW-1:0] high_x;
    logic signed [PosW-1:0] high_y;
    logic signed [PosW-1:0] high_z;
    logic [VolW-1:0]        volume;
    logic                   clipped;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic            cfg_we_i = 1'b0;
  cfg_idx_e        cfg_idx_i = CfgHalfLength;
  logic [LenW-1:0] cfg_data_i = '0;

  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    func_i = 1'b0;
  logic signed [PosW-1:0]  pos_x_i = '0;
  logic signed [PosW-1:0]  pos_y_i = '0;
  logic signed [PosW-1:0]  pos_z_i = '0;
  logic signed [QuatW-1:0] quat_w_i = '0;
  logic signed [QuatW-1:0] quat_x_i = '0;
  logic signed [QuatW-1:0] quat_y_i = '0;
  logic signed [QuatW-1:0] quat_z_i = '0;

  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [PosW-1:0] low_x_o;
  logic signed [PosW-1:0] low_y_o;
  logic signed [PosW-1:0] low_z_o;
  logic signed [PosW-1:0] high_x_o;
  logic signed [PosW-1:0] high_y_o;
  logic signed [PosW-1:0] high_z_o;
  logic [VolW-1:0]        volume_o;
  logic                   clipped_o;

  capsule_t        capsule_q [$];
  box_t            box_q [$];
  capsule_t        cur_capsule;
  logic [LenW-1:0] half_len = HalfLengthReset;
  logic [LenW-1:0] pad_rad = RadiusReset;
  bit              calm = 1'b0;
  bit              taken = 1'b0;
  int              gap_left = 0;
  int              stall_left = 0;
  int              fails = 0;
  int              cycle_cnt = 0;

  capsule_oriented_bounding_box_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .quat_w_i    (quat_w_i),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .low_x_o     (low_x_o),
    .low_y_o     (low_y_o),
    .low_z_o     (low_z_o),
    .high_x_o    (high_x_o),
    .high_y_o    (high_y_o),
    .high_z_o    (high_z_o),
    .volume_o    (volume_o),
    .clipped_o   (clipped_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic signed [PosW-1:0] clamp_q16(input longint v, inout bit clip);
    if (v > longint'(32'sh7fffffff)) begin
      clip = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -longint'(64'sh80000000)) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return v[PosW-1:0];
  endfunction

  // Rotate the z axis, scale by the half length, order the ends, and in mode 0 pad them and take the volume.
  function automatic box_t capsule_box(capsule_t c);
    box_t         b;
    longint       qw, qx, qy, qz;
    longint       pos [3];
    longint       ax [3];
    longint       lo [3];
    longint       hi [3];
    longint       prod, top, end_a, end_b;
    logic [63:0]  mag;
    logic [63:0]  ext [3];
    logic [127:0] vol_full;
    bit           clip;
    qw = c.quat_w;
    qx = c.quat_x;
    qy = c.quat_y;
    qz = c.quat_z;
    pos[0] = c.pos_x;
    pos[1] = c.pos_y;
    pos[2] = c.pos_z;
    clip = 1'b0;
    ax[0] = 2 * (qx * qz + qw * qy);
    ax[1] = 2 * (qy * qz - qw * qx);
    ax[2] = (longint'(1) <<< 28) - 2 * (qx * qx + qy * qy);
    for (int k = 0; k < 3; k++) begin
      prod = ax[k] * longint'({33'd0, half_len});
      mag = (prod < 0) ? -prod : prod;
      top = longint'((mag + 64'd134217728) >> 28);
      if (prod < 0) top = -top;
      end_a = pos[k] - top;
      end_b = pos[k] + top;
      lo[k] = (end_a < end_b) ? end_a : end_b;
      hi[k] = (end_a < end_b) ? end_b : end_a;
      if (!c.func) begin
        lo[k] = lo[k] - longint'({33'd0, pad_rad});
        hi[k] = hi[k] + longint'({33'd0, pad_rad});
      end
      ext[k] = 64'(hi[k] - lo[k]);
    end
    b.volume = '0;
    if (!c.func) begin
      vol_full = {64'd0, ext[0]} * {64'd0, ext[1]} * {64'd0, ext[2]};
      if (vol_full[127:96] != 0) begin
        clip = 1'b1;
        b.volume = '1;
      end else begin
        b.volume = vol_full[95:32];
      end
    end
    b.low_x  = clamp_q16(lo[0], clip);
    b.low_y  = clamp_q16(lo[1], clip);
    b.low_z  = clamp_q16(lo[2], clip);
    b.high_x = clamp_q16(hi[0], clip);
    b.high_y = clamp_q16(hi[1], clip);
    b.high_z = clamp_q16(hi[2], clip);
    b.clipped = clip;
    return b;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  function automatic logic signed [PosW-1:0] rand_pos();
    case ($urandom_range(3))
      0: return 32'(int'($urandom_range(2 ** 21)) - 2 ** 20);
      1: begin
        if ($urandom_range(1)) return 32'h7fffffff - 32'($urandom_range(2 ** 18));
        return 32'h80000000 + 32'($urandom_range(2 ** 18));
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [QuatW-1:0] rand_comp();
    case ($urandom_range(7))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return 16'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic push_capsule(bit func, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    capsule_t c;
    c.func = func;
    c.pos_x = px;
    c.pos_y = py;
    c.pos_z = pz;
    c.quat_w = w;
    c.quat_x = x;
    c.quat_y = y;
    c.quat_z = z;
    capsule_q.push_back(c);
  endtask

  // Unit quaternions for most words, raw components for the rest.
  task automatic push_random(int count);
    real a [4];
    real n;
    logic [15:0] q [4];
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) != 0) begin
        do begin
          n = 0.0;
          for (int j = 0; j < 4; j++) begin
            a[j] = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
            n = n + a[j] * a[j];
          end
        end while (n < 0.01);
        n = $sqrt(n);
        for (int j = 0; j < 4; j++) q[j] = 16'($rtoi(a[j] / n * 16384.0));
      end else begin
        for (int j = 0; j < 4; j++) q[j] = rand_comp();
      end
      push_capsule($urandom_range(1), rand_pos(), rand_pos(), rand_pos(), q[0], q[1], q[2], q[3]);
    end
  endtask

  task automatic wait_drained();
    while (capsule_q.size() != 0 || in_valid_i || box_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [LenW-1:0] hl, logic [LenW-1:0] rad);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgHalfLength;
    cfg_data_i <= hl;
    half_len = hl;
    @(negedge clk_i);
    cfg_idx_i <= CfgRadius;
    cfg_data_i <= rad;
    pad_rad = rad;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [LenW-1:0] rand_len();
    if ($urandom_range(1)) return LenW'($urandom_range(2 ** 20));
    return LenW'($urandom);
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // identity, flipped signs, half turns, quarter turns, degenerate quaternions, clipping ends
    push_capsule(1'b0, 32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    push_capsule(1'b1, 32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    push_capsule(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 -16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    push_capsule(1'b0, 32'h80000000, 32'h80000000, 32'h80000000,
                 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    push_capsule(1'b1, 32'h7fffffff, 32'h80000000, 32'h0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    push_capsule(1'b0, 32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    push_capsule(1'b0, 32'h10000, 32'hffff0000, 32'h0, 16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
    push_capsule(1'b1, 32'h0, 32'h0, 32'h0, 16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
    push_capsule(1'b0, 32'h12345678, 32'h0, 32'hedcba988, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    push_capsule(1'b0, 32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    push_capsule(1'b1, 32'h0, 32'h0, 32'h0, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    push_capsule(1'b0, 32'h0, 32'h0, 32'h0, 16'sd0, 16'sd8192, -16'sd8192, 16'sd8192);
    push_capsule(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    push_capsule(1'b1, 32'h80000000, 32'h80000000, 32'h80000000,
                 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    push_capsule(1'b0, 32'h7fff8000, 32'h80007fff, 32'h0, 16'sd16383, -16'sd1, 16'sd1, 16'sd0);
    push_random(RandPerPhase);

    for (int p = 1; p < NumPhases; p++) begin
      case (p)
        1: set_regs('0, '0);
        2: set_regs(LenMax, LenMax);
        3: set_regs(LenMax, '0);
        4: set_regs('0, LenMax);
        default: set_regs(rand_len(), rand_len());
      endcase
      calm = (p % 3 == 1);
      push_random(RandPerPhase);
    end

    while (capsule_q.size() != 0 || in_valid_i || box_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0 && box_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Record the prediction for each word taken by the core.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      box_q.push_back(capsule_box(cur_capsule));
      taken = 1'b1;
    end
  end

  // Hold the word while stalled, advance to the next one once taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || taken)) begin
      taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (capsule_q.size() != 0) begin
        cur_capsule = capsule_q.pop_front();
        func_i <= cur_capsule.func;
        pos_x_i <= cur_capsule.pos_x;
        pos_y_i <= cur_capsule.pos_y;
        pos_z_i <= cur_capsule.pos_z;
        quat_w_i <= cur_capsule.quat_w;
        quat_x_i <= cur_capsule.quat_x;
        quat_y_i <= cur_capsule.quat_y;
        quat_z_i <= cur_capsule.quat_z;
        in_valid_i <= 1'b1;
        gap_left = (!calm && $urandom_range(99) < 30) ? idle_len() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!calm && $urandom_range(99) < 20) stall_left = idle_len();
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    box_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (box_q.size() == 0) begin
        $error("result word with no box pending");
        fails++;
      end else begin
        want = box_q.pop_front();
        check_field("low_x", want.low_x, low_x_o);
        check_field("low_y", want.low_y, low_y_o);
        check_field("low_z", want.low_z, low_z_o);
        check_field("high_x", want.high_x, high_x_o);
        check_field("high_y", want.high_y, high_y_o);
        check_field("high_z", want.high_z, high_z_o);
        check_field("volume", want.volume, volume_o);
        check_field("clipped", want.clipped, clipped_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule
